// ===== design/wms_pkg.sv =====
// Shared constants and codes for the waypoint motion stepper.
// No dependencies; the top level refers to this package by scoped names.
package wms_pkg;

   localparam int FRAC_BITS = 16;
   localparam logic [31:0] TENTH = 32'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
   localparam logic [63:0] HALF_LSB = 64'd1 << (FRAC_BITS - 1);
   localparam logic [31:0] ALL32 = 32'hFFFF_FFFF;

   localparam logic [1:0] ACT_GOAL = 2'd0;
   localparam logic [1:0] ACT_TICK = 2'd1;
   localparam logic [1:0] ACT_CANCEL = 2'd2;

   localparam logic [2:0] KIND_ACCEPTED = 3'd0;
   localparam logic [2:0] KIND_REJECTED = 3'd1;
   localparam logic [2:0] KIND_FEEDBACK = 3'd2;
   localparam logic [2:0] KIND_SUCCEEDED = 3'd3;
   localparam logic [2:0] KIND_CANCELED = 3'd4;

   localparam logic [1:0] RSN_NONE = 2'd0;
   localparam logic [1:0] RSN_SPEED = 2'd1;
   localparam logic [1:0] RSN_TOLERANCE = 2'd2;
   localparam logic [1:0] RSN_BUSY = 2'd3;

endpackage

// ===== design/wms_sqrt.sv =====
// Iterative 64-bit integer square root, one result bit per cycle.
// Depends on nothing beyond its ports; used by the waypoint motion stepper.
module wms_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] value,
   output logic        done,
   output logic [32:0] root
);

   logic [63:0] rem_ff, rem_in;
   logic [63:0] res_ff, res_in;
   logic [63:0] bit_ff;
   logic [4:0]  cnt_ff;
   logic        run_ff;
   logic        done_ff;
   logic [63:0] trial;

   always_comb begin
      trial = res_ff + bit_ff;
      if (rem_ff >= trial) begin
         rem_in = rem_ff - trial;
         res_in = (res_ff >> 1) + bit_ff;
      end else begin
         rem_in = rem_ff;
         res_in = res_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rem_ff <= value;
            res_ff <= '0;
            bit_ff <= 64'd1 << 62;
            cnt_ff <= '0;
            run_ff <= 1'b1;
         end else if (run_ff) begin
            rem_ff <= rem_in;
            res_ff <= res_in;
            bit_ff <= bit_ff >> 2;
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               run_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = res_ff[32:0];

endmodule

// ===== design/wms_div.sv =====
// Iterative restoring divider: 64-bit dividend by 33-bit divisor, one bit per cycle.
// Depends on nothing beyond its ports; used by the waypoint motion stepper.
module wms_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [32:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);

   logic [32:0] rem_ff;
   logic [63:0] quo_ff;
   logic [32:0] div_ff;
   logic [5:0]  cnt_ff;
   logic        run_ff;
   logic        done_ff;
   logic [33:0] shifted;
   logic        fits;
   logic [33:0] reduced;

   always_comb begin
      shifted = {rem_ff, quo_ff[63]};
      fits = shifted >= {1'b0, div_ff};
      reduced = fits ? shifted - {1'b0, div_ff} : shifted;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rem_ff <= '0;
            quo_ff <= dividend;
            div_ff <= divisor;
            cnt_ff <= '0;
            run_ff <= 1'b1;
         end else if (run_ff) begin
            rem_ff <= reduced[32:0];
            quo_ff <= {quo_ff[62:0], fits};
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               run_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== design/waypoint_motion_stepper.sv =====
// Top level of the waypoint motion stepper: sequencer, shared multiplier and result register.
// Depends on wms_pkg, wms_sqrt and wms_div.
//
// Usage: the request channel (req_valid, req_stall, req_* fields) carries one action per
// transaction: a new goal, a 100 ms tick or a cancel. The response channel (rsp_valid,
// rsp_stall, rsp_* fields) returns at most one transaction per request.
// A rejected goal is answered straight from the idle state; an accepted goal from the scale state.
// A tick or cancel while busy runs two squarings on the shared 32x32 multiplier and a square
// root; a tick that moves adds two products and two divisions.
// Idle ticks and cancels, and unknown actions, are taken with no response.
// One request is in flight at a time and req_stall is high until its response is registered.
// A finished response waits in the output register while rsp_stall is high; a new request
// is taken only once that register is free or being emptied in the same cycle.
// Reset is synchronous and active high: position, goal and tick count return to zero,
// the block goes idle and no response is pending.
module waypoint_motion_stepper (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_action,
   input  logic signed [31:0] req_target_x,
   input  logic signed [31:0] req_target_y,
   input  logic signed [31:0] req_arrive_tolerance,
   input  logic signed [31:0] req_speed_limit,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_kind,
   output logic [1:0]         rsp_reject_reason,
   output logic [31:0]        rsp_distance_left,
   output logic signed [31:0] rsp_pos_x_out,
   output logic signed [31:0] rsp_pos_y_out,
   output logic [31:0]        rsp_elapsed_ticks
);

   typedef enum logic [3:0] {
      S_IDLE, S_SCALE, S_SQX, S_SQY, S_ROOT_GO, S_ROOT, S_DECIDE,
      S_DIVX_GO, S_DIVX, S_DIVY_GO, S_DIVY
   } state_type;

   state_type          state_ff;
   logic signed [31:0] pos_x_ff, pos_y_ff, goal_x_ff, goal_y_ff, tol_ff;
   logic [31:0]        step_limit_ff, tick_count_ff, speed_ff;
   logic               busy_ff, is_tick_ff;
   logic [31:0]        ax_ff, ay_ff;
   logic               negx_ff, negy_ff;
   logic [63:0]        s_ff, t_ff;
   logic [32:0]        full_ff;
   logic [31:0]        step_ff;
   logic               rsp_valid_ff;
   logic [2:0]         kind_ff;
   logic [1:0]         reason_ff;
   logic [31:0]        dist_ff, elapsed_ff;

   logic [31:0] mul_a, mul_b;
   logic [63:0] product;
   logic        slot_free, accept;
   logic [32:0] dx, dy;
   logic [64:0] sq_sum;
   logic        huge;
   logic [63:0] root_arg;
   logic        sqrt_start, sqrt_done, div_start, div_done;
   logic [32:0] root;
   logic [63:0] quotient;
   logic [32:0] full;
   logic [31:0] rep;
   logic [63:0] scaled;
   logic [31:0] mv;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || !slot_free;
   assign accept = req_valid && !req_stall;

   always_comb begin
      dx = {goal_x_ff[31], goal_x_ff} - {pos_x_ff[31], pos_x_ff};
      dy = {goal_y_ff[31], goal_y_ff} - {pos_y_ff[31], pos_y_ff};
      sq_sum = {1'b0, s_ff} + {1'b0, t_ff};
      huge = sq_sum[64];
      root_arg = huge ? (s_ff >> 2) + (t_ff >> 2) : sq_sum[63:0];
      full = huge ? {root[31:0], 1'b0} : root;
      rep = (huge || full[32]) ? wms_pkg::ALL32 : full[31:0];
      unique case (state_ff)
         S_SCALE:   begin mul_a = speed_ff; mul_b = wms_pkg::TENTH; end
         S_SQX:     begin mul_a = ax_ff;    mul_b = ax_ff;          end
         S_SQY:     begin mul_a = ay_ff;    mul_b = ay_ff;          end
         S_DIVX_GO: begin mul_a = step_ff;  mul_b = ax_ff;          end
         S_DIVY_GO: begin mul_a = step_ff;  mul_b = ay_ff;          end
         default:   begin mul_a = '0;       mul_b = '0;             end
      endcase
      product = 64'(mul_a) * 64'(mul_b);
      scaled = product + wms_pkg::HALF_LSB;
      sqrt_start = state_ff == S_ROOT_GO;
      div_start = (state_ff == S_DIVX_GO) || (state_ff == S_DIVY_GO);
      mv = quotient[31:0];
   end

   wms_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sqrt_start),
      .value (root_arg),
      .done  (sqrt_done),
      .root  (root)
   );

   wms_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (product),
      .divisor  (full_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         goal_x_ff <= '0;
         goal_y_ff <= '0;
         tol_ff <= '0;
         step_limit_ff <= '0;
         tick_count_ff <= '0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  ax_ff <= dx[32] ? 32'(-dx) : dx[31:0];
                  ay_ff <= dy[32] ? 32'(-dy) : dy[31:0];
                  negx_ff <= dx[32];
                  negy_ff <= dy[32];
                  is_tick_ff <= req_action == wms_pkg::ACT_TICK;
                  if (req_action == wms_pkg::ACT_GOAL) begin
                     kind_ff <= wms_pkg::KIND_REJECTED;
                     dist_ff <= '0;
                     elapsed_ff <= '0;
                     if (req_speed_limit <= 0) begin
                        reason_ff <= wms_pkg::RSN_SPEED;
                        rsp_valid_ff <= 1'b1;
                     end else if (req_arrive_tolerance <= 0) begin
                        reason_ff <= wms_pkg::RSN_TOLERANCE;
                        rsp_valid_ff <= 1'b1;
                     end else if (busy_ff) begin
                        reason_ff <= wms_pkg::RSN_BUSY;
                        rsp_valid_ff <= 1'b1;
                     end else begin
                        goal_x_ff <= req_target_x;
                        goal_y_ff <= req_target_y;
                        tol_ff <= req_arrive_tolerance;
                        speed_ff <= req_speed_limit;
                        state_ff <= S_SCALE;
                     end
                  end else if (busy_ff && (req_action == wms_pkg::ACT_TICK ||
                                           req_action == wms_pkg::ACT_CANCEL)) begin
                     state_ff <= S_SQX;
                  end
               end
            end
            S_SCALE: begin
               step_limit_ff <= scaled[wms_pkg::FRAC_BITS +: 32];
               tick_count_ff <= '0;
               busy_ff <= 1'b1;
               kind_ff <= wms_pkg::KIND_ACCEPTED;
               reason_ff <= wms_pkg::RSN_NONE;
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            S_SQX: begin
               s_ff <= product;
               state_ff <= S_SQY;
            end
            S_SQY: begin
               t_ff <= product;
               state_ff <= S_ROOT_GO;
            end
            S_ROOT_GO: begin
               state_ff <= S_ROOT;
            end
            S_ROOT: begin
               if (sqrt_done) begin
                  full_ff <= full;
                  dist_ff <= rep;
                  elapsed_ff <= tick_count_ff;
                  reason_ff <= wms_pkg::RSN_NONE;
                  state_ff <= S_DECIDE;
               end
            end
            S_DECIDE: begin
               if (!is_tick_ff) begin
                  kind_ff <= wms_pkg::KIND_CANCELED;
                  busy_ff <= 1'b0;
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  if (tick_count_ff != wms_pkg::ALL32) begin
                     tick_count_ff <= tick_count_ff + 32'd1;
                  end
                  if (full_ff <= {1'b0, tol_ff}) begin
                     kind_ff <= wms_pkg::KIND_SUCCEEDED;
                     busy_ff <= 1'b0;
                     rsp_valid_ff <= 1'b1;
                     state_ff <= S_IDLE;
                  end else begin
                     kind_ff <= wms_pkg::KIND_FEEDBACK;
                     step_ff <= ({1'b0, step_limit_ff} < full_ff) ? step_limit_ff
                                                                : full_ff[31:0];
                     state_ff <= S_DIVX_GO;
                  end
               end
            end
            S_DIVX_GO: begin
               state_ff <= S_DIVX;
            end
            S_DIVX: begin
               if (div_done) begin
                  pos_x_ff <= negx_ff ? pos_x_ff - mv : pos_x_ff + mv;
                  state_ff <= S_DIVY_GO;
               end
            end
            S_DIVY_GO: begin
               state_ff <= S_DIVY;
            end
            S_DIVY: begin
               if (div_done) begin
                  pos_y_ff <= negy_ff ? pos_y_ff - mv : pos_y_ff + mv;
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind = kind_ff;
   assign rsp_reject_reason = reason_ff;
   assign rsp_distance_left = dist_ff;
   assign rsp_pos_x_out = pos_x_ff;
   assign rsp_pos_y_out = pos_y_ff;
   assign rsp_elapsed_ticks = elapsed_ff;

   a_stall_while_working: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> req_stall)
      else $error("request taken while a transaction is in progress");

   a_reject_has_reason: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && kind_ff == wms_pkg::KIND_REJECTED) |-> reason_ff != wms_pkg::RSN_NONE)
      else $error("rejected goal without a reason");

   a_finish_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (kind_ff == wms_pkg::KIND_SUCCEEDED ||
                        kind_ff == wms_pkg::KIND_CANCELED)) |-> !busy_ff)
      else $error("goal still running after success or cancel");

   a_no_response_while_working: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE && state_ff != S_SCALE) |-> !rsp_valid_ff)
      else $error("response pending during computation");

endmodule
